@@ sv/sit_pkg.sv @@
// sit_pkg: shared types and constants for the sorted insertion table.
// Holds the capacity, field widths, channel payload structs and codes.
// No dependencies.
`timescale 1ns / 1ps

package sit_pkg;

  localparam int CAPACITY = 64;               // number of table cells, 2..64 with the POS_W and ECNT_W below
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;                // width of position / read_index fields
  localparam int ECNT_W   = 7;                // width of entry_count field
  localparam int IDX_W    = $clog2(CAPACITY); // cell index width
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read path: cells are picked in groups, within each group first, then the group
  localparam int GRP_W    = 3;
  localparam int GRP      = 1 << GRP_W;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_READ
  } state_e;

  typedef struct packed {
    cmd_e             command;
    val_t             new_value;
    logic [POS_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    val_t              read_value;
    logic [ECNT_W-1:0] entry_count;
    status_e           status;
  } out_t;

  // what one cell hands to its right-hand neighbor
  typedef struct packed {
    logic shift;   // this cell moves up (empty, or holds a larger value)
    val_t value;
  } link_t;

endpackage

@@ sv/sit_cell.sv @@
// sit_cell: one cell of the insertion chain; holds a single table value.
// Compares against the incoming value and, on insert, keeps its value or takes
// the new value or its left neighbor's value. Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_cell (
  input  logic          clk_i,
  input  logic          upd_i,
  input  logic          occ_i,
  input  sit_pkg::val_t new_value_i,
  input  sit_pkg::link_t left_i,
  output sit_pkg::link_t link_o,
  output sit_pkg::val_t value_o
);

  sit_pkg::val_t value_q;
  sit_pkg::val_t value_d;
  logic          shift;

  // equal values stay put, so the new one lands after them
  assign shift = !occ_i || ($signed(value_q) > $signed(new_value_i));

  always_comb begin
    value_d = value_q;
    if (shift) begin
      value_d = left_i.shift ? left_i.value : new_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      value_q <= value_d;
    end
  end

  assign link_o.shift = shift;
  assign link_o.value = value_q;
  assign value_o      = value_q;

endmodule

@@ sv/sit_read_sel.sv @@
// sit_read_sel: two-step read select over the cell row.
// The first step registers one value per group of cells, the second picks the group.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_read_sel (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  sit_pkg::val_t             values_i [sit_pkg::CAPACITY],
  input  logic [sit_pkg::POS_W-1:0] index_i,
  output sit_pkg::val_t             value_o
);

  sit_pkg::val_t                               grp_q [sit_pkg::NGRP];
  sit_pkg::val_t                               grp_d [sit_pkg::NGRP];
  logic [sit_pkg::GRP_W-1:0]                   idx_lo;
  logic [sit_pkg::POS_W-sit_pkg::GRP_W-1:0]    idx_hi;

  assign idx_lo = index_i[sit_pkg::GRP_W-1:0];
  assign idx_hi = index_i[sit_pkg::POS_W-1:sit_pkg::GRP_W];

  always_comb begin
    for (int g = 0; g < sit_pkg::NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < sit_pkg::GRP; k++) begin
        if ((g * sit_pkg::GRP + k < sit_pkg::CAPACITY) && (int'(idx_lo) == k)) begin
          grp_d[g] = values_i[g * sit_pkg::GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    value_o = '0;
    for (int g = 0; g < sit_pkg::NGRP; g++) begin
      if (int'(idx_hi) == g) begin
        value_o = grp_q[g];
      end
    end
  end

endmodule

@@ sv/sorted_insertion_table.sv @@
// sorted_insertion_table: ascending table of signed values kept in a cell chain.
// Instantiates sit_cell (one per entry) and sit_read_sel; depends on sit_pkg.
//
//  channel | valid       | stall        | payload                  | moves
//  in      | in_valid_i  | in_stall_o   | in_data_i  (sit_pkg::in_t)  | command
//  out     | out_valid_o | out_stall_i  | out_data_o (sit_pkg::out_t) | one result
//
// One item at a time: an insert goes through S_WORK into the output register,
// a read through S_WORK, the read select's group register (one value per group of 8 cells) and S_READ.
// Every cell compares and shifts in the same cycle, so insert time does not
// depend on the fill level. Back-pressure on out holds the item in the chain
// until the output register frees; the next item is taken once it is loaded.
// Reset clears the entry count and control; cell contents are not cleared.
`timescale 1ns / 1ps

module sorted_insertion_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sit_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sit_pkg::out_t out_data_o
);

  sit_pkg::state_e state_q, state_d;
  sit_pkg::in_t    req_q;
  logic [sit_pkg::CNT_W-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  sit_pkg::out_t   out_q, out_d;

  logic            out_free;
  logic            full;
  logic            out_range;
  logic            upd;
  logic            grp_load;
  logic [sit_pkg::IDX_W-1:0] pos;

  sit_pkg::link_t  links  [sit_pkg::CAPACITY];
  sit_pkg::val_t   values [sit_pkg::CAPACITY];
  sit_pkg::val_t   rd_value;

  for (genvar i = 0; i < sit_pkg::CAPACITY; i++) begin : g_cell
    sit_pkg::link_t left;
    logic           occ;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = links[i-1];
    end
    assign occ = count_q > sit_pkg::CNT_W'(i);
    sit_cell u_cell (
      .clk_i       (clk_i),
      .upd_i       (upd),
      .occ_i       (occ),
      .new_value_i (req_q.new_value),
      .left_i      (left),
      .link_o      (links[i]),
      .value_o     (values[i])
    );
  end

  // shift flags form a run of zeros then ones; position is the first one
  always_comb begin
    pos = '0;
    for (int i = 0; i < sit_pkg::CAPACITY; i++) begin
      if (links[i].shift && ((i == 0) || !links[(i == 0) ? 0 : i - 1].shift)) begin
        pos = pos | sit_pkg::IDX_W'(i);
      end
    end
  end

  sit_read_sel u_read_sel (
    .clk_i    (clk_i),
    .load_i   (grp_load),
    .values_i (values),
    .index_i  (req_q.read_index),
    .value_o  (rd_value)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = count_q == sit_pkg::CNT_W'(sit_pkg::CAPACITY);
  assign out_range = sit_pkg::CMP_W'(req_q.read_index) >= sit_pkg::CMP_W'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    upd         = 1'b0;
    grp_load    = 1'b0;
    case (state_q)
      sit_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sit_pkg::S_WORK;
        end
      end
      sit_pkg::S_WORK: begin
        if (req_q.command == sit_pkg::CMD_READ) begin
          grp_load = 1'b1;
          state_d  = sit_pkg::S_READ;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = sit_pkg::S_IDLE;
          if (full) begin
            out_d.position    = '0;
            out_d.read_value  = '0;
            out_d.entry_count = sit_pkg::ECNT_W'(count_q);
            out_d.status      = sit_pkg::ST_FULL;
          end else begin
            upd               = 1'b1;
            count_d           = count_q + sit_pkg::CNT_W'(1);
            out_d.position    = sit_pkg::POS_W'(pos);
            out_d.read_value  = '0;
            out_d.entry_count = sit_pkg::ECNT_W'(count_d);
            out_d.status      = sit_pkg::ST_OK;
          end
        end
      end
      sit_pkg::S_READ: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          state_d           = sit_pkg::S_IDLE;
          out_d.position    = req_q.read_index;
          out_d.entry_count = sit_pkg::ECNT_W'(count_q);
          out_d.read_value  = out_range ? '0 : rd_value;
          out_d.status      = out_range ? sit_pkg::ST_RANGE : sit_pkg::ST_OK;
        end
      end
      default: begin
        state_d = sit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sit_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign in_stall_o  = state_q != sit_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/sit_checker.sv @@
// sit_checker: port-level checks for sorted_insertion_table, bound to the top.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input sit_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sit_pkg::out_t out_data_o
);

  // a result held under stall stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("out payload changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sit_pkg::ST_FULL |->
      out_data_o.entry_count == sit_pkg::ECNT_W'(sit_pkg::CAPACITY) &&
      out_data_o.position == '0 && out_data_o.read_value == '0)
    else $error("full result with bad fields");

  a_range_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == sit_pkg::ST_RANGE |->
      out_data_o.read_value == '0 &&
      sit_pkg::CMP_W'(out_data_o.position) >= sit_pkg::CMP_W'(out_data_o.entry_count))
    else $error("out-of-range result with bad fields");

endmodule

bind sorted_insertion_table sit_checker u_sit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
